/* rtl/tst_pkg.sv */
// shared types and constants for the type signature tokenizer
package tst_pkg;

  localparam int POSITION_BITS = 16;
  localparam int LINE_BITS     = 16;
  localparam int FIELD_BITS    = 16;
  localparam int KIND_BITS     = 5;
  localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_FIRST  = 3'd1,
    MODE_DEC    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_IDENT  = 3'd4,
    MODE_COLON  = 3'd5,
    MODE_HYPHEN = 3'd6
  } scan_mode_e;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_NUMBER = 5'd0,
    KIND_HEX    = 5'd1,
    KIND_IDENT  = 5'd2,
    KIND_LPAREN = 5'd3,
    KIND_RPAREN = 5'd4,
    KIND_LT     = 5'd5,
    KIND_GT     = 5'd6,
    KIND_COLON  = 5'd7,
    KIND_DCOLON = 5'd8,
    KIND_BTICK  = 5'd9,
    KIND_QUOTE  = 5'd10,
    KIND_DOT    = 5'd11,
    KIND_COMMA  = 5'd12,
    KIND_AMP    = 5'd13,
    KIND_STAR   = 5'd14,
    KIND_ARROW  = 5'd15,
    KIND_HYPHEN = 5'd16,
    KIND_ERROR  = 5'd17,
    KIND_EOF    = 5'd18
  } token_kind_e;

  typedef struct packed {
    token_kind_e           kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] length;
    logic [FIELD_BITS-1:0] line;
    logic                  last;
  } token_t;

  // tokens produced by one scanned item, count of valid ones from tok0 up
  typedef struct packed {
    token_t     tok0;
    token_t     tok1;
    logic [1:0] count;
  } scan_res_t;

endpackage

/* rtl/tst_scan.sv */
// scanner state and per-byte token decode
module tst_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic                eot_i,
  output tst_pkg::scan_res_t  res_o
);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam int PB = tst_pkg::POSITION_BITS;
  localparam int LB = tst_pkg::LINE_BITS;
  localparam int FB = tst_pkg::FIELD_BITS;

  function automatic logic is_digit(logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    is_hex = is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  function automatic logic is_word(logic [7:0] b);
    is_word = is_alpha(b) || is_digit(b) || (b == CH_UNDER);
  endfunction

  function automatic tst_pkg::token_kind_e punct_kind(logic [7:0] b);
    case (b)
      8'h28:   punct_kind = tst_pkg::KIND_LPAREN;
      8'h29:   punct_kind = tst_pkg::KIND_RPAREN;
      8'h3C:   punct_kind = tst_pkg::KIND_LT;
      8'h3E:   punct_kind = tst_pkg::KIND_GT;
      8'h60:   punct_kind = tst_pkg::KIND_BTICK;
      8'h27:   punct_kind = tst_pkg::KIND_QUOTE;
      8'h2E:   punct_kind = tst_pkg::KIND_DOT;
      8'h2C:   punct_kind = tst_pkg::KIND_COMMA;
      8'h26:   punct_kind = tst_pkg::KIND_AMP;
      8'h2A:   punct_kind = tst_pkg::KIND_STAR;
      default: punct_kind = tst_pkg::KIND_ERROR;
    endcase
  endfunction

  function automatic logic [FB-1:0] clamp_field(logic [31:0] v);
    clamp_field = (v > 32'(tst_pkg::FIELD_MAX)) ? tst_pkg::FIELD_MAX : v[FB-1:0];
  endfunction

  tst_pkg::scan_mode_e mode_q, mode_d;
  logic [PB-1:0] pos_q, pos_d;
  logic [PB-1:0] start_q, start_d;
  logic [FB-1:0] len_q, len_d;
  logic [LB-1:0] line_q, line_d;

  // decode of the byte as if scanned between tokens
  logic                idle_skip, idle_nl, idle_emit;
  tst_pkg::scan_mode_e idle_mode;
  tst_pkg::token_kind_e idle_kind;

  // decode against the pending token
  logic                has_pend, ext, pair, term;
  tst_pkg::scan_mode_e ext_mode;
  tst_pkg::token_kind_e pend_kind, pair_kind;

  logic [FB-1:0] pos_f, start_f, line_f;
  logic [1:0]    cnt;

  always_comb begin
    idle_skip = (byte_i == CH_SPACE) || (byte_i == CH_TAB) || (byte_i == CH_CR);
    idle_nl   = (byte_i == CH_LF);
    idle_kind = punct_kind(byte_i);
    if (is_digit(byte_i)) begin
      idle_mode = tst_pkg::MODE_FIRST;
    end else if (is_alpha(byte_i) || (byte_i == CH_UNDER)) begin
      idle_mode = tst_pkg::MODE_IDENT;
    end else if (byte_i == CH_COLON) begin
      idle_mode = tst_pkg::MODE_COLON;
    end else if (byte_i == CH_HYPHEN) begin
      idle_mode = tst_pkg::MODE_HYPHEN;
    end else begin
      idle_mode = tst_pkg::MODE_IDLE;
    end
    idle_emit = !idle_skip && !idle_nl && (idle_mode == tst_pkg::MODE_IDLE);
  end

  always_comb begin
    has_pend  = 1'b1;
    ext       = 1'b0;
    ext_mode  = mode_q;
    pair      = 1'b0;
    pair_kind = tst_pkg::KIND_DCOLON;
    pend_kind = tst_pkg::KIND_NUMBER;
    case (mode_q)
      tst_pkg::MODE_FIRST: begin
        if (byte_i == CH_X) begin
          ext      = 1'b1;
          ext_mode = tst_pkg::MODE_HEX;
        end else if (is_digit(byte_i)) begin
          ext      = 1'b1;
          ext_mode = tst_pkg::MODE_DEC;
        end
      end
      tst_pkg::MODE_DEC: begin
        ext = is_digit(byte_i);
      end
      tst_pkg::MODE_HEX: begin
        pend_kind = tst_pkg::KIND_HEX;
        ext       = is_hex(byte_i);
      end
      tst_pkg::MODE_IDENT: begin
        pend_kind = tst_pkg::KIND_IDENT;
        ext       = is_word(byte_i);
      end
      tst_pkg::MODE_COLON: begin
        pend_kind = tst_pkg::KIND_COLON;
        pair      = (byte_i == CH_COLON);
        pair_kind = tst_pkg::KIND_DCOLON;
      end
      tst_pkg::MODE_HYPHEN: begin
        pend_kind = tst_pkg::KIND_HYPHEN;
        pair      = (byte_i == CH_GT);
        pair_kind = tst_pkg::KIND_ARROW;
      end
      default: begin
        has_pend = 1'b0;
      end
    endcase
    term = has_pend && !ext && !pair;
  end

  // next state
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    line_d  = line_q;
    if (fire_i) begin
      if (eot_i) begin
        mode_d  = tst_pkg::MODE_IDLE;
        pos_d   = '0;
        start_d = '0;
        len_d   = '0;
        line_d  = LB'(1);
      end else begin
        pos_d = (&pos_q) ? pos_q : pos_q + PB'(1);
        if (ext) begin
          mode_d = ext_mode;
          len_d  = (&len_q) ? len_q : len_q + FB'(1);
        end else if (pair) begin
          mode_d = tst_pkg::MODE_IDLE;
        end else begin
          mode_d = idle_mode;
          if (!idle_skip && !idle_nl) begin
            start_d = pos_q;
            len_d   = FB'(1);
          end
          if (idle_nl && !(&line_q)) begin
            line_d = line_q + LB'(1);
          end
        end
      end
    end
  end

  // token outputs
  always_comb begin
    pos_f   = clamp_field(32'(pos_q));
    start_f = clamp_field(32'(start_q));
    line_f  = clamp_field(32'(line_q));
    res_o   = '0;
    cnt     = 2'd0;

    res_o.tok0.kind   = pend_kind;
    res_o.tok0.start  = start_f;
    res_o.tok0.length = len_q;
    res_o.tok0.line   = line_f;
    res_o.tok1.kind   = idle_kind;
    res_o.tok1.start  = pos_f;
    res_o.tok1.length = FB'(1);
    res_o.tok1.line   = line_f;

    if (eot_i) begin
      res_o.tok1.kind   = tst_pkg::KIND_EOF;
      res_o.tok1.length = '0;
      if (has_pend) begin
        cnt = 2'd2;
      end else begin
        res_o.tok0 = res_o.tok1;
        cnt        = 2'd1;
      end
    end else if (pair) begin
      res_o.tok0.kind   = pair_kind;
      res_o.tok0.length = FB'(2);
      cnt               = 2'd1;
    end else if (term) begin
      cnt = idle_emit ? 2'd2 : 2'd1;
    end else if (!ext && idle_emit) begin
      res_o.tok0 = res_o.tok1;
      cnt        = 2'd1;
    end

    res_o.tok0.last = (cnt == 2'd1);
    res_o.tok1.last = 1'b1;
    res_o.count     = fire_i ? cnt : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tst_pkg::MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      line_q  <= LB'(1);
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      line_q  <= line_d;
    end
  end

endmodule

/* rtl/tst_fifo.sv */
// small token queue taking up to two tokens per cycle, one out per cycle while ready_i is high
module tst_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tst_pkg::scan_res_t push_i,
  output logic               room_o,
  output tst_pkg::token_t    tok_o,
  output logic               valid_o,
  input  logic               ready_i
);

  localparam int PW = tst_pkg::FIFO_PTR_BITS;
  localparam int CW = tst_pkg::FIFO_CNT_BITS;

  tst_pkg::token_t mem_q [tst_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  // room for a full pair of tokens
  assign room_o  = (cnt_q <= CW'(tst_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + PW'(push_i.count);
    rd_d  = rd_q + PW'(pop);
    cnt_d = cnt_q + CW'(push_i.count) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + PW'(1)] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/type_signature_tokenizer.sv */
// Streaming tokenizer for type-signature text: takes one byte per request (tuser set marks
// end of text) and returns tokens as kind, start offset, length and line, tlast on the final
// token a request causes. Requests are taken at one per cycle while the token queue has room
// for a pair of tokens: a byte register feeds the scanner, which decodes it combinationally
// and writes zero, one or two tokens into a four-entry token queue. The output side drains one
// token per cycle while the receiver is ready, so a sustained rate of one byte per cycle holds
// while bytes average at most one token each; a byte that closes a pending token and is itself
// a punctuator yields two tokens. A token passes through the byte register and the token queue
// before it is offered at the output. Offsets, lengths and lines saturate at 65535.
module type_signature_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] text_byte
  input  logic        s_axis_tuser_i,  // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // [4:0] token_kind, [20:5] token_start,
                                       // [36:21] token_length, [52:37] token_line, rest zero
  output logic        m_axis_tlast_o   // last_of_item
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic       s_acc, fire, room;

  tst_pkg::scan_res_t res;
  tst_pkg::token_t    tok;

  assign fire            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = s_acc ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_eot_q  <= s_axis_tuser_i;
    end
  end

  tst_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .eot_i  (in_eot_q),
    .res_o  (res)
  );

  tst_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .room_o  (room),
    .tok_o   (tok),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {3'b000, tok.line, tok.length, tok.start, tok.kind};
  assign m_axis_tlast_o = tok.last;

endmodule
